[rtl/pkht_pkg.sv]
// package for the pointer key hash table
// shared types, status and opcode codes, and the bucket hash function
// no dependencies
package pkht_pkg;

	localparam logic [1:0] OP_PUT    = 2'd0;
	localparam logic [1:0] OP_GET    = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3; // behaves as get

	localparam logic [2:0] ST_FOUND    = 3'd0;
	localparam logic [2:0] ST_INSERTED = 3'd1;
	localparam logic [2:0] ST_MISS     = 3'd2;
	localparam logic [2:0] ST_ABSENT   = 3'd3;
	localparam logic [2:0] ST_FULL     = 3'd4;

	localparam int ID_W = 31;

	// controller to datapath
	typedef struct packed {
		logic load;      // capture key, opcode, start hash
		logic hash_step; // run one mixing round
		logic head_rd;   // start chain at bucket head
		logic node_rd;   // read node at cur
		logic advance;   // cur <= link, prev <= cur
		logic do_insert;
		logic do_remove;
		logic set_result;
	} pkht_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic hash_done;
		logic cur_nil;
		logic key_match;
		logic steps_out;
		logic [1:0] op;
	} pkht_sts_t;

	function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
		return (x << r) | (x >> (32 - r));
	endfunction

	// one of seven final-mix rounds; state packed as {a,b,c}
	function automatic logic [95:0] mix_round(input logic [95:0] s, input logic [2:0] rnd);
		logic [31:0] a, b, c;
		a = s[95:64];
		b = s[63:32];
		c = s[31:0];
		case (rnd)
			3'd0: begin c = (c ^ b) - rotl(b, 14); end
			3'd1: begin a = (a ^ c) - rotl(c, 11); end
			3'd2: begin b = (b ^ a) - rotl(a, 25); end
			3'd3: begin c = (c ^ b) - rotl(b, 16); end
			3'd4: begin a = (a ^ c) - rotl(c, 4); end
			3'd5: begin b = (b ^ a) - rotl(a, 14); end
			3'd6: begin c = (c ^ b) - rotl(b, 24); end
			default: begin c = c; end
		endcase
		return {a, b, c};
	endfunction

endpackage

[rtl/pkht_ctrl.sv]
// controller state machine of the hash table
// sequences hash, chain walk and update; uses pkht_pkg
module pkht_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_fire,
	input  logic                out_free,
	input  pkht_pkg::pkht_sts_t sts,
	output logic                busy,
	output pkht_pkg::pkht_cmd_t cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_HASH = 3'd1;
	localparam logic [2:0] S_HEAD = 3'd2;
	localparam logic [2:0] S_READ = 3'd3;
	localparam logic [2:0] S_CMP  = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [2:0] state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					cmd.load = 1'b1;
					state_d = S_HASH;
				end
			end
			S_HASH: begin
				cmd.hash_step = 1'b1;
				if (sts.hash_done) state_d = S_HEAD;
			end
			S_HEAD: begin
				cmd.head_rd = 1'b1;
				state_d = S_READ;
			end
			S_READ: begin
				// cur valid; issue node read or finish on nil or step limit
				if (sts.cur_nil || sts.steps_out) state_d = S_DONE;
				else begin
					cmd.node_rd = 1'b1;
					state_d = S_CMP;
				end
			end
			S_CMP: begin
				if (sts.key_match) state_d = S_DONE;
				else begin
					cmd.advance = 1'b1;
					state_d = S_READ;
				end
			end
			S_DONE: begin
				if (out_free) begin
					cmd.set_result = 1'b1;
					if (sts.op == pkht_pkg::OP_PUT && !sts.key_match) cmd.do_insert = 1'b1;
					if (sts.op == pkht_pkg::OP_REMOVE && sts.key_match) cmd.do_remove = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

[rtl/pkht_dp.sv]
// datapath of the hash table: hash unit, node memories, chain walk, result
// driven by pkht_ctrl commands; uses pkht_pkg
module pkht_dp #(
	parameter int HASH_BITS    = 8,
	parameter int POOL_ENTRIES = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [1:0]          op_in,
	input  logic [63:0]         key_in,
	input  pkht_pkg::pkht_cmd_t cmd,
	output pkht_pkg::pkht_sts_t sts,
	output logic [2:0]          res_status,
	output logic [pkht_pkg::ID_W-1:0] res_id
);

	localparam int BUCKETS = 1 << HASH_BITS;
	localparam int PW = $clog2(POOL_ENTRIES + 1);
	localparam int IW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
	localparam logic [PW-1:0] NIL = PW'(POOL_ENTRIES);

	logic [63:0] node_keys [POOL_ENTRIES];
	logic [pkht_pkg::ID_W-1:0] node_ids [POOL_ENTRIES];
	logic [PW-1:0] node_links [POOL_ENTRIES];
	logic [PW-1:0] bucket_heads [BUCKETS];
	logic [BUCKETS-1:0] head_vld_q;

	logic [1:0]  op_q;
	logic [63:0] key_q;
	logic [95:0] hs_q;
	logic [95:0] hs_nxt;
	logic [2:0]  rnd_q;
	logic [HASH_BITS-1:0] bucket_q;
	logic [PW-1:0] cur_q, prev_q, head_q;
	logic [PW:0]   steps_q;
	logic [63:0]   rd_key_q;
	logic [pkht_pkg::ID_W-1:0] rd_id_q;
	logic [PW-1:0] rd_link_q;
	logic [PW-1:0] free_head_q, pool_used_q;
	logic [pkht_pkg::ID_W-1:0] next_id_q;
	logic [PW-1:0] head_rd;
	logic          relink_q;

	assign head_rd = head_vld_q[bucket_q] ? bucket_heads[bucket_q] : NIL;
	assign hs_nxt  = pkht_pkg::mix_round(hs_q, rnd_q);

	// free list head link, read from link memory at the head read
	logic [PW-1:0] free_link_q;
	logic [PW-1:0] new_node;
	logic          have_node;
	assign have_node = (free_head_q != NIL) || (pool_used_q != NIL);
	assign new_node  = (free_head_q != NIL) ? free_head_q : pool_used_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_vld_q  <= '0;
			free_head_q <= NIL;
			pool_used_q <= '0;
			next_id_q   <= '0;
			rnd_q       <= '0;
			relink_q    <= 1'b0;
		end else begin
			if (cmd.load) rnd_q <= '0;
			if (cmd.hash_step) rnd_q <= rnd_q + 3'd1;
			// predecessor link is rewritten in the cycle after a remove
			relink_q <= cmd.do_remove && (prev_q != NIL);
			if (cmd.do_insert && have_node) begin
				head_vld_q[bucket_q] <= 1'b1;
				next_id_q <= next_id_q + 1'b1;
				if (free_head_q != NIL) free_head_q <= free_link_q;
				else pool_used_q <= pool_used_q + 1'b1;
			end
			if (cmd.do_remove) begin
				if (prev_q == NIL) head_vld_q[bucket_q] <= 1'b1;
				free_head_q <= cur_q;
			end
		end
	end

	// compare pending flag, set in the cycle after the node read
	logic cmp_pend_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cmp_pend_q <= 1'b0;
		else cmp_pend_q <= cmd.node_rd;
	end

	logic hit_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) hit_q <= 1'b0;
		else if (cmd.load) hit_q <= 1'b0;
		else if (cmp_pend_q && rd_key_q == key_q) hit_q <= 1'b1;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= op_in;
			key_q <= key_in;
			hs_q  <= {32'hdeadbeef + 32'd8 + key_in[31:0],
				32'hdeadbeef + 32'd8 + key_in[63:32], 32'hdeadbeef + 32'd8};
		end
		if (cmd.hash_step) begin
			hs_q <= hs_nxt;
			if (rnd_q == 3'd6)
				bucket_q <= hs_nxt[HASH_BITS-1:0];
		end
		if (cmd.head_rd) begin
			cur_q       <= head_rd;
			head_q      <= head_rd;
			prev_q      <= NIL;
			steps_q     <= '0;
			free_link_q <= node_links[free_head_q[IW-1:0]];
		end
		if (cmd.node_rd) begin
			rd_key_q  <= node_keys[cur_q[IW-1:0]];
			rd_id_q   <= node_ids[cur_q[IW-1:0]];
			rd_link_q <= node_links[cur_q[IW-1:0]];
			steps_q   <= steps_q + 1'b1;
		end
		if (cmd.advance) begin
			prev_q <= cur_q;
			cur_q  <= rd_link_q;
		end
		if (cmd.do_insert && have_node) begin
			node_keys[new_node[IW-1:0]]  <= key_q;
			node_ids[new_node[IW-1:0]]   <= next_id_q;
			node_links[new_node[IW-1:0]] <= head_q;
			bucket_heads[bucket_q]       <= new_node;
		end
		if (cmd.do_remove) begin
			if (prev_q == NIL) bucket_heads[bucket_q] <= rd_link_q;
			node_links[cur_q[IW-1:0]] <= free_head_q;
		end
		if (relink_q) node_links[prev_q[IW-1:0]] <= rd_link_q;
		if (cmd.set_result) begin
			if (hit_q) begin
				res_status <= pkht_pkg::ST_FOUND;
				res_id     <= rd_id_q;
			end else begin
				res_id <= '0;
				case (op_q)
					pkht_pkg::OP_PUT: begin
						if (have_node) begin
							res_status <= pkht_pkg::ST_INSERTED;
							res_id     <= next_id_q;
						end else res_status <= pkht_pkg::ST_FULL;
					end
					pkht_pkg::OP_REMOVE: res_status <= pkht_pkg::ST_ABSENT;
					default: res_status <= pkht_pkg::ST_MISS;
				endcase
			end
		end
	end

	assign sts.hash_done = (rnd_q == 3'd6);
	assign sts.cur_nil   = (cur_q == NIL);
	assign sts.key_match = hit_q || (cmp_pend_q && rd_key_q == key_q);
	assign sts.steps_out = (steps_q >= (PW+1)'(POOL_ENTRIES));
	assign sts.op        = op_q;

endmodule

[rtl/pointer_key_hash_table.sv]
// pointer key hash table: 64-bit key to sequential id, chained buckets, free list
// sequence: 7 hash rounds, bucket head read, a node read and compare per chain node,
// then the result word; a miss ends on a nil link or the step limit
// one word at a time, taken only while idle; a full result register stalls it
// arst_n clears bucket valid bits, free list, pool count and id counter at once
// node memories are not cleared; only linked nodes are ever read
module pointer_key_hash_table #(
	parameter int HASH_BITS    = 8,
	parameter int POOL_ENTRIES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // opcode[1:0], key[65:2], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // status[2:0], entry_id[33:3], zero pad
);

	pkht_pkg::pkht_cmd_t cmd;
	pkht_pkg::pkht_sts_t sts;
	logic busy;
	logic in_fire;
	logic out_free;
	logic [2:0] res_status;
	logic [pkht_pkg::ID_W-1:0] res_id;
	logic out_vld_q;

	// accept a new word while idle, even if a result still waits
	assign s_tready = !busy;
	assign in_fire  = s_tvalid && s_tready;
	// result register free when empty or drained this cycle
	assign out_free = !out_vld_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_vld_q <= 1'b0;
		else if (cmd.set_result) out_vld_q <= 1'b1;
		else if (m_tready) out_vld_q <= 1'b0;
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {6'd0, res_id, res_status};

	pkht_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .out_free(out_free),
		.sts(sts), .busy(busy), .cmd(cmd)
	);

	pkht_dp #(.HASH_BITS(HASH_BITS), .POOL_ENTRIES(POOL_ENTRIES)) u_dp (
		.clk(clk), .arst_n(arst_n), .op_in(s_tdata[1:0]), .key_in(s_tdata[65:2]),
		.cmd(cmd), .sts(sts), .res_status(res_status), .res_id(res_id)
	);

endmodule

[rtl/pkht_checker.sv]
// port checker for the pointer key hash table, bound to the top level
// depends on pointer_key_hash_table ports and pkht_pkg status codes
module pkht_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word dropped while stalled");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2:0] <= pkht_pkg::ST_FULL)
		else $error("status out of range");

	a_no_id_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[2:0] == pkht_pkg::ST_MISS || m_tdata[2:0] == pkht_pkg::ST_ABSENT
		|| m_tdata[2:0] == pkht_pkg::ST_FULL)
		|-> m_tdata[33:3] == '0)
		else $error("id on a miss result");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second word taken during work");

endmodule

bind pointer_key_hash_table pkht_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
